### src/uasmd_pkg.sv
// ----------------------------------------------------------------------------
// uasmd_pkg
// Operation codes and shared types for the unsigned add/sub/mul/div unit.
// ----------------------------------------------------------------------------
package uasmd_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

endpackage

### src/uasmd_div_stage.sv
// ----------------------------------------------------------------------------
// uasmd_div_stage
// One registered stage of restoring division: resolves STEPS quotient bits.
// ----------------------------------------------------------------------------
module uasmd_div_stage #(
    parameter int WIDTH = 32,
    parameter int STEPS = 4
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] rem_in,
    input  logic             rem_hi_in,
    input  logic [WIDTH-1:0] num_in,
    input  logic [WIDTH-1:0] quo_in,
    input  logic [WIDTH-1:0] den_in,
    output logic [WIDTH-1:0] rem_out,
    output logic             rem_hi_out,
    output logic [WIDTH-1:0] num_out,
    output logic [WIDTH-1:0] quo_out,
    output logic [WIDTH-1:0] den_out
);

    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] num_next;
    logic [WIDTH-1:0] quo_next;

    logic [WIDTH-1:0] rem_reg;
    logic             rem_hi_reg;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] den_reg;

    always_comb
    begin
        logic             hi;
        logic [WIDTH-1:0] r;
        logic [WIDTH-1:0] n;
        logic [WIDTH-1:0] q;
        r  = rem_in;
        hi = rem_hi_in;
        n  = num_in;
        q  = quo_in;
        for (int s = 0; s < STEPS; s++)
        begin
            hi = r[WIDTH-1];
            r  = {r[WIDTH-2:0], n[WIDTH-1]};
            n  = {n[WIDTH-2:0], 1'b0};
            if (hi || (r >= den_in))
            begin
                r = r - den_in;
                q = {q[WIDTH-2:0], 1'b1};
            end
            else
            begin
                q = {q[WIDTH-2:0], 1'b0};
            end
        end
        rem_next = r;
        num_next = n;
        quo_next = q;
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        rem_hi_reg <= 1'b0;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        den_reg    <= den_in;
    end

    assign rem_out    = rem_reg;
    assign rem_hi_out = rem_hi_reg;
    assign num_out    = num_reg;
    assign quo_out    = quo_reg;
    assign den_out    = den_reg;

endmodule

### src/uasmd_mul_stage.sv
// ----------------------------------------------------------------------------
// uasmd_mul_stage
// Two-stage low-half multiplier built from registered half-width-split products.
// ----------------------------------------------------------------------------
module uasmd_mul_stage #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] prod
);

    localparam int HALF = WIDTH / 2;
    localparam int UPR  = WIDTH - HALF;

    logic [WIDTH-1:0] ll_reg;
    logic [WIDTH-1:0] lh_reg;
    logic [WIDTH-1:0] hl_reg;
    logic [WIDTH-1:0] prod_reg;
    logic [WIDTH-1:0] prod_next;

    always_ff @(posedge clk)
    begin
        ll_reg <= WIDTH'({{UPR{1'b0}}, a[HALF-1:0]} * {{UPR{1'b0}}, b[HALF-1:0]});
        lh_reg <= WIDTH'({{HALF{1'b0}}, a[WIDTH-1:HALF]} * {{UPR{1'b0}}, b[HALF-1:0]});
        hl_reg <= WIDTH'({{UPR{1'b0}}, a[HALF-1:0]} * {{HALF{1'b0}}, b[WIDTH-1:HALF]});
    end

    assign prod_next = ll_reg + ((lh_reg + hl_reg) << HALF);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### src/unsigned_add_sub_mul_div_unit.sv
// ----------------------------------------------------------------------------
// unsigned_add_sub_mul_div_unit
// Pipelined unsigned ALU: wrapping add, clamped subtract, low-half multiply
// and restoring divide (zero on a zero divisor).
// ----------------------------------------------------------------------------
// channel   ports              handshake
// input     op, a, b           start & !busy
// output    result             done (one cycle)
//
// One item enters each cycle; busy is held low. Depth is set by the divider
// chain, four quotient bits per stage, the last stage taking the rest. All
// ops travel the same depth so results leave in order. Reset clears the
// valid bits only. The receiver cannot stall.
// ----------------------------------------------------------------------------
module unsigned_add_sub_mul_div_unit #(
    parameter int WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  uasmd_pkg::op_t      op,
    input  logic [WIDTH-1:0]    a,
    input  logic [WIDTH-1:0]    b,
    output logic                done,
    output logic [WIDTH-1:0]    result
);

    import uasmd_pkg::*;

    localparam int STEPS  = 4;
    localparam int NSTAGE = (WIDTH + STEPS - 1) / STEPS;
    localparam int LAST   = WIDTH - STEPS * (NSTAGE - 1);

    logic [WIDTH-1:0] rem_w    [NSTAGE+1];
    logic             rem_hi_w [NSTAGE+1];
    logic [WIDTH-1:0] num_w    [NSTAGE+1];
    logic [WIDTH-1:0] quo_w    [NSTAGE+1];
    logic [WIDTH-1:0] den_w    [NSTAGE+1];

    logic [NSTAGE:0]  vld_reg;
    logic [NSTAGE:0]  vld_next;
    op_t              op_reg  [NSTAGE];
    logic [WIDTH-1:0] val_reg [NSTAGE+1];
    logic             bz_reg  [NSTAGE];
    logic [WIDTH-1:0] prod;
    logic [WIDTH-1:0] simple_next;
    logic [WIDTH-1:0] result_reg;
    logic [WIDTH-1:0] result_next;
    logic             done_reg;

    assign rem_w[0]    = '0;
    assign rem_hi_w[0] = 1'b0;
    assign num_w[0]    = a;
    assign quo_w[0]    = '0;
    assign den_w[0]    = b;

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_div
        uasmd_div_stage #(
            .WIDTH (WIDTH),
            .STEPS ((g == NSTAGE - 1) ? LAST : STEPS)
        ) u_stage (
            .clk        (clk),
            .rem_in     (rem_w[g]),
            .rem_hi_in  (rem_hi_w[g]),
            .num_in     (num_w[g]),
            .quo_in     (quo_w[g]),
            .den_in     (den_w[g]),
            .rem_out    (rem_w[g+1]),
            .rem_hi_out (rem_hi_w[g+1]),
            .num_out    (num_w[g+1]),
            .quo_out    (quo_w[g+1]),
            .den_out    (den_w[g+1])
        );
    end

    uasmd_mul_stage #(.WIDTH(WIDTH)) u_mul (
        .clk  (clk),
        .a    (a),
        .b    (b),
        .prod (prod)
    );

    always_comb
    begin
        unique case (op)
            OP_ADD:  simple_next = a + b;
            OP_SUB:  simple_next = (b > a) ? '0 : a - b;
            default: simple_next = '0;
        endcase
    end

    assign vld_next = {vld_reg[NSTAGE-1:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[NSTAGE];
        end
    end

    // advance op and side data alongside the divider chain
    always_ff @(posedge clk)
    begin
        op_reg[0]  <= op;
        val_reg[0] <= simple_next;
        bz_reg[0]  <= (b == '0);
        for (int i = 1; i < NSTAGE; i++)
        begin
            op_reg[i] <= op_reg[i-1];
            bz_reg[i] <= bz_reg[i-1];
        end
        for (int i = 1; i <= NSTAGE; i++)
        begin
            if (i == NSTAGE && op_reg[i-1] == OP_DIV)
                val_reg[i] <= bz_reg[i-1] ? '0 : quo_w[NSTAGE];
            else if (i == 2 && op_reg[i-1] == OP_MUL)
                val_reg[i] <= prod;
            else
                val_reg[i] <= val_reg[i-1];
        end
    end

    always_comb
    begin
        result_next = val_reg[NSTAGE];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
